// ===== rtl/rlm_pkg.sv =====
package rlm_pkg;

  // field and register widths
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned LEVEL_W    = 15;
  localparam int unsigned SCALED_W   = 16;
  localparam int unsigned FRAMES_W   = 9;
  localparam int unsigned CFG_W      = 15;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned S_TDATA_W  = 32;
  localparam int unsigned M_TDATA_W  = 48;

  // datapath widths that do not depend on the block length
  localparam int unsigned SQ_W       = 29;  // square of a halved sample, up to 2^28
  localparam int unsigned RAD_W      = 30;  // mean of squares, below 2^29
  localparam int unsigned ROOT_STEPS = RAD_W / 2;
  localparam int unsigned PROD_W     = LEVEL_W + SCALED_W;

  localparam int unsigned MAX_FRAMES_DEF = 256;

  localparam logic [FRAMES_W-1:0] FRAMES_RST     = 9'd256;
  localparam logic [CFG_W-1:0]    FULL_SCALE_RST = 15'd5571;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 1'd1;

  typedef struct packed {
    logic acc;
    logic mean_ld;
    logic div_step;
    logic root_ld;
    logic root_step;
    logic smooth;
    logic scale_ld;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic block_done;
    logic step_last;
    logic out_stall;
  } status_t;

endpackage

// ===== rtl/rlm_ctrl.sv =====
module rlm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_tvalid_i,
  output logic            s_tready_o,
  input  rlm_pkg::status_t status_i,
  output rlm_pkg::cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_MEAN_LD   = 4'd1;
  localparam logic [3:0] S_MEAN_DIV  = 4'd2;
  localparam logic [3:0] S_ROOT_LD   = 4'd3;
  localparam logic [3:0] S_ROOT      = 4'd4;
  localparam logic [3:0] S_SMOOTH    = 4'd5;
  localparam logic [3:0] S_SCALE_LD  = 4'd6;
  localparam logic [3:0] S_SCALE_DIV = 4'd7;
  localparam logic [3:0] S_EMIT      = 4'd8;

  logic [3:0] state_q, state_d;
  logic       accept;

  assign s_tready_o = (state_q == S_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.acc = accept;
        if (accept && status_i.block_done) begin
          state_d = S_MEAN_LD;
        end
      end
      S_MEAN_LD: begin
        cmd_o.mean_ld = 1'b1;
        state_d       = S_MEAN_DIV;
      end
      S_MEAN_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.step_last) begin
          state_d = S_ROOT_LD;
        end
      end
      S_ROOT_LD: begin
        cmd_o.root_ld = 1'b1;
        state_d       = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (status_i.step_last) begin
          state_d = S_SMOOTH;
        end
      end
      S_SMOOTH: begin
        cmd_o.smooth = 1'b1;
        state_d      = S_SCALE_LD;
      end
      S_SCALE_LD: begin
        cmd_o.scale_ld = 1'b1;
        state_d        = S_SCALE_DIV;
      end
      S_SCALE_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.step_last) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        // wait here while the previous result is still held
        if (!status_i.out_stall) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/rlm_datapath.sv =====
module rlm_datapath #(
  parameter int unsigned MAX_FRAMES = rlm_pkg::MAX_FRAMES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rlm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rlm_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic signed [rlm_pkg::SAMPLE_W-1:0] left_i,
  input  logic signed [rlm_pkg::SAMPLE_W-1:0] right_i,
  input  logic                                m_tready_i,
  output logic                                m_tvalid_o,
  output logic [rlm_pkg::LEVEL_W-1:0]         block_level_o,
  output logic [rlm_pkg::LEVEL_W-1:0]         smoothed_o,
  output logic [rlm_pkg::SCALED_W-1:0]        scaled_o,
  input  rlm_pkg::cmd_t                       cmd_i,
  output rlm_pkg::status_t                    status_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int unsigned SUM_W  = rlm_pkg::SQ_W + 1 + $clog2(MAX_FRAMES);
  localparam int unsigned DVD_W  = (SUM_W > rlm_pkg::PROD_W) ? SUM_W : rlm_pkg::PROD_W;
  localparam int unsigned DVS_W  = (CNT_W + 1 > rlm_pkg::CFG_W) ? CNT_W + 1 : rlm_pkg::CFG_W;
  localparam int unsigned LEN_W  = (CNT_W + 1 > rlm_pkg::FRAMES_W) ? CNT_W + 1
                                                                   : rlm_pkg::FRAMES_W;
  localparam int unsigned STEP_W = $clog2(DVD_W);
  localparam int unsigned LW     = rlm_pkg::LEVEL_W;
  localparam int unsigned RW     = rlm_pkg::RAD_W;
  localparam int unsigned SREM_W = LW + 2;

  // configuration
  logic [rlm_pkg::FRAMES_W-1:0] frames_q;
  logic [rlm_pkg::CFG_W-1:0]    full_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q     <= rlm_pkg::FRAMES_RST;
      full_scale_q <= rlm_pkg::FULL_SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rlm_pkg::REG_FRAMES:     frames_q     <= cfg_wdata_i[rlm_pkg::FRAMES_W-1:0];
        rlm_pkg::REG_FULL_SCALE: full_scale_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // accumulation of squared halved samples
  logic [SUM_W-1:0]   sum_q;
  logic [CNT_W-1:0]   count_q;
  logic signed [LW-1:0]   half_l, half_r;
  logic signed [2*LW-1:0] prod_l, prod_r;
  logic [CNT_W:0]     count_inc;
  logic [LEN_W-1:0]   len_raw, len;

  assign half_l    = left_i[rlm_pkg::SAMPLE_W-1:1];
  assign half_r    = right_i[rlm_pkg::SAMPLE_W-1:1];
  assign prod_l    = half_l * half_l;
  assign prod_r    = half_r * half_r;
  assign count_inc = (CNT_W + 1)'(count_q) + 1'b1;

  always_comb begin
    len_raw = LEN_W'(frames_q);
    if (len_raw == '0) begin
      len = LEN_W'(1);
    end else if (len_raw > LEN_W'(MAX_FRAMES)) begin
      len = LEN_W'(MAX_FRAMES);
    end else begin
      len = len_raw;
    end
  end

  assign status_o.block_done = (LEN_W'(count_inc) >= len);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
    end else if (cmd_i.emit) begin
      sum_q   <= '0;
      count_q <= '0;
    end else if (cmd_i.acc) begin
      sum_q   <= sum_q + SUM_W'(prod_l[rlm_pkg::SQ_W-1:0])
                       + SUM_W'(prod_r[rlm_pkg::SQ_W-1:0]);
      count_q <= count_inc[CNT_W-1:0];
    end
  end

  // shared step counter for the divider and the root
  logic [STEP_W-1:0] step_q;

  assign status_o.step_last = (step_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mean_ld || cmd_i.scale_ld) begin
      step_q <= STEP_W'(DVD_W - 1);
    end else if (cmd_i.root_ld) begin
      step_q <= STEP_W'(rlm_pkg::ROOT_STEPS - 1);
    end else if (cmd_i.div_step || cmd_i.root_step) begin
      step_q <= step_q - 1'b1;
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [DVD_W-1:0] dvd_q;
  logic [DVS_W-1:0] drem_q, dvs_q;
  logic [DVS_W:0]   dshift, ddiff;
  logic             dge;
  logic [LW-1:0]    smooth_q;
  logic [rlm_pkg::PROD_W-1:0] scale_prod;
  logic [rlm_pkg::CFG_W-1:0]  fs_eff;

  assign dshift     = {drem_q, dvd_q[DVD_W-1]};
  assign dge        = (dshift >= {1'b0, dvs_q});
  assign ddiff      = dshift - {1'b0, dvs_q};
  // times 65535 as times 65536 minus one
  assign scale_prod = {smooth_q, 16'd0} - rlm_pkg::PROD_W'(smooth_q);
  assign fs_eff     = (full_scale_q == '0) ? rlm_pkg::CFG_W'(1) : full_scale_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mean_ld) begin
      dvd_q  <= DVD_W'(sum_q);
      drem_q <= '0;
      dvs_q  <= DVS_W'({count_q, 1'b0});
    end else if (cmd_i.scale_ld) begin
      dvd_q  <= DVD_W'(scale_prod);
      drem_q <= '0;
      dvs_q  <= DVS_W'(fs_eff);
    end else if (cmd_i.div_step) begin
      dvd_q  <= {dvd_q[DVD_W-2:0], dge};
      drem_q <= dge ? ddiff[DVS_W-1:0] : dshift[DVS_W-1:0];
    end
  end

  // digit-by-digit square root, one root bit per cycle
  logic [RW-1:0]     rad_q;
  logic [SREM_W-1:0] srem_q;
  logic [LW-1:0]     root_q;
  logic [SREM_W+1:0] sshift, strial, sdiff;
  logic              sge;

  assign sshift = {srem_q, rad_q[RW-1:RW-2]};
  assign strial = (SREM_W + 2)'({root_q, 2'b01});
  assign sge    = (sshift >= strial);
  assign sdiff  = sshift - strial;

  always_ff @(posedge clk_i) begin
    if (cmd_i.root_ld) begin
      rad_q  <= dvd_q[RW-1:0];
      srem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      rad_q  <= {rad_q[RW-3:0], 2'b00};
      srem_q <= sge ? sdiff[SREM_W-1:0] : sshift[SREM_W-1:0];
      root_q <= {root_q[LW-2:0], sge};
    end
  end

  // smoothing: three quarters old plus one quarter new
  logic [LW+1:0] smooth_sum;

  assign smooth_sum = ((LW + 2)'(smooth_q) << 1) + (LW + 2)'(smooth_q) + (LW + 2)'(root_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q <= '0;
    end else if (cmd_i.smooth) begin
      smooth_q <= smooth_sum[LW+1:2];
    end
  end

  // output register
  logic                         out_valid_q;
  logic [LW-1:0]                block_level_q, smoothed_q;
  logic [rlm_pkg::SCALED_W-1:0] scaled_q;

  assign status_o.out_stall = out_valid_q && !m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      block_level_q <= root_q;
      smoothed_q    <= smooth_q;
      scaled_q      <= (dvd_q[DVD_W-1:rlm_pkg::SCALED_W] != '0) ? '1
                                                              : dvd_q[rlm_pkg::SCALED_W-1:0];
    end
  end

  assign m_tvalid_o    = out_valid_q;
  assign block_level_o = block_level_q;
  assign smoothed_o    = smoothed_q;
  assign scaled_o      = scaled_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_FRAMES))
    else $error("frame count beyond block limit");

  a_emit_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !(out_valid_q && !m_tready_i))
    else $error("result loaded over a held result");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> (count_q == '0) && (sum_q == '0))
    else $error("block state not cleared after result");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (block_level_q <= LW'(16384)) && (smoothed_q <= LW'(16384)))
    else $error("level out of range");

endmodule

// ===== rtl/rms_level_meter.sv =====
// channel      dir  handshake                    payload
// s_axis       in   s_axis_tvalid/s_axis_tready  left_sample, right_sample
// m_axis       out  m_axis_tvalid/m_axis_tready  block_level, smoothed_out, scaled_out
// cfg          in   cfg_we_i (no wait)           cfg_idx_i, cfg_wdata_i
//
// a frame is taken while the control is idle; the frame that closes a block
// starts a computation by the bit-serial divider, run twice, and the
// bit-serial square root. no frame is taken while that computation runs.
// the result sits in an output register; the next block fills while it waits,
// and a finished block waits in the last state until the register is free.
// reset clears sum, count, smoothed level and registers to their defaults.
module rms_level_meter #(
  parameter int unsigned MAX_FRAMES = rlm_pkg::MAX_FRAMES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [rlm_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // left_sample, right_sample
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [rlm_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // block_level, smoothed_out,
                                                          // scaled_out, zero pad
  input  logic                             cfg_we_i,
  input  logic [rlm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rlm_pkg::CFG_W-1:0]        cfg_wdata_i
);

  localparam int unsigned LW  = rlm_pkg::LEVEL_W;
  localparam int unsigned SCW = rlm_pkg::SCALED_W;
  localparam int unsigned SW  = rlm_pkg::SAMPLE_W;
  localparam int unsigned PAD = rlm_pkg::M_TDATA_W - 2 * LW - SCW;

  rlm_pkg::cmd_t    cmd;
  rlm_pkg::status_t status;

  logic [LW-1:0]  block_level, smoothed_out;
  logic [SCW-1:0] scaled_out;

  rlm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rlm_datapath #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .left_i        (s_axis_tdata[SW-1:0]),
    .right_i       (s_axis_tdata[2*SW-1:SW]),
    .m_tready_i    (m_axis_tready),
    .m_tvalid_o    (m_axis_tvalid),
    .block_level_o (block_level),
    .smoothed_o    (smoothed_out),
    .scaled_o      (scaled_out),
    .cmd_i         (cmd),
    .status_o      (status)
  );

  assign m_axis_tdata = {{PAD{1'b0}}, scaled_out, smoothed_out, block_level};

endmodule

// ===== test/rms_level_meter_checker.sv =====
`timescale 1ns / 1ps

module rms_level_meter_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [rlm_pkg::S_TDATA_W-1:0] s_tdata_i,   // left_sample, right_sample
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic [rlm_pkg::M_TDATA_W-1:0] m_tdata_i,   // block_level, smoothed_out,
                                                     // scaled_out, zero pad
  input  logic                          cfg_we_i,
  input  logic [rlm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rlm_pkg::CFG_W-1:0]     cfg_wdata_i,
  output int                            errors_o,
  output int                            pending_o
);

  typedef struct {
    logic [rlm_pkg::LEVEL_W-1:0]  block_level;
    logic [rlm_pkg::LEVEL_W-1:0]  smoothed;
    logic [rlm_pkg::SCALED_W-1:0] scaled;
  } level_t;

  level_t                       level_q[$];
  logic [37:0]                  square_acc;
  int unsigned                  frames_taken;
  logic [rlm_pkg::LEVEL_W-1:0]  smooth_lvl;
  logic [rlm_pkg::FRAMES_W-1:0] frames_reg;
  logic [rlm_pkg::CFG_W-1:0]    full_scale_reg;
  int                           err_cnt;

  // halving is an arithmetic shift, so it rounds toward minus infinity
  function automatic longint unsigned halved_square(logic [rlm_pkg::SAMPLE_W-1:0] s);
    longint h;
    h = longint'($signed(s));
    h = h >>> 1;
    return longint'(h * h);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root, trial;
    root = 0;
    for (int b = 20; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  task automatic take_frame(logic [rlm_pkg::S_TDATA_W-1:0] beat);
    int unsigned     len;
    longint unsigned mean, lvl, fs, scaled;
    level_t          lv;
    len = frames_reg;
    if (len == 0) len = 1;
    if (len > rlm_pkg::MAX_FRAMES_DEF) len = rlm_pkg::MAX_FRAMES_DEF;
    square_acc = square_acc + halved_square(beat[15:0]) + halved_square(beat[31:16]);
    frames_taken++;
    // a shortened block closes as soon as the count reaches or passes the new length
    if (frames_taken < len) return;
    mean = longint'(square_acc) / (2 * longint'(frames_taken));
    lvl = floor_sqrt(mean);
    if (lvl > 32767) lvl = 32767;
    smooth_lvl = rlm_pkg::LEVEL_W'((3 * longint'(smooth_lvl) + lvl) >> 2);
    fs = (full_scale_reg == 0) ? 1 : full_scale_reg;
    scaled = longint'(smooth_lvl) * 65535 / fs;
    if (scaled > 65535) scaled = 65535;
    lv.block_level = rlm_pkg::LEVEL_W'(lvl);
    lv.smoothed = smooth_lvl;
    lv.scaled = rlm_pkg::SCALED_W'(scaled);
    level_q.insert(level_q.size(), lv);
    square_acc = '0;
    frames_taken = 0;
  endtask

  task automatic check_level(logic [rlm_pkg::M_TDATA_W-1:0] beat);
    level_t exp_lv;
    if (level_q.size() == 0) begin
      $display("%0t: unexpected level beat %h", $time, beat);
      err_cnt++;
      return;
    end
    exp_lv = level_q.pop_front();
    if (beat[14:0] !== exp_lv.block_level) begin
      $display("%0t: block_level expected %0d actual %0d", $time, exp_lv.block_level,
               beat[14:0]);
      err_cnt++;
    end
    if (beat[29:15] !== exp_lv.smoothed) begin
      $display("%0t: smoothed_out expected %0d actual %0d", $time, exp_lv.smoothed,
               beat[29:15]);
      err_cnt++;
    end
    if (beat[45:30] !== exp_lv.scaled) begin
      $display("%0t: scaled_out expected %0d actual %0d", $time, exp_lv.scaled,
               beat[45:30]);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q.delete();
      square_acc = '0;
      frames_taken = 0;
      smooth_lvl = '0;
      frames_reg = rlm_pkg::FRAMES_RST;
      full_scale_reg = rlm_pkg::FULL_SCALE_RST;
      err_cnt = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rlm_pkg::REG_FRAMES:     frames_reg = cfg_wdata_i[rlm_pkg::FRAMES_W-1:0];
          rlm_pkg::REG_FULL_SCALE: full_scale_reg = cfg_wdata_i;
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) check_level(m_tdata_i);
      if (s_tvalid_i && s_tready_i) take_frame(s_tdata_i);
    end
    errors_o  <= err_cnt;
    pending_o <= level_q.size();
  end

endmodule

// ===== test/rms_level_meter_test.sv =====
`timescale 1ns / 1ps

module rms_level_meter_test;

  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES   = 600;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [rlm_pkg::S_TDATA_W-1:0] s_axis_tdata;   // left_sample, right_sample
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [rlm_pkg::M_TDATA_W-1:0] m_axis_tdata;   // block_level, smoothed_out,
                                                 // scaled_out, zero pad
  logic                          cfg_we_i;
  logic [rlm_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [rlm_pkg::CFG_W-1:0]     cfg_wdata_i;

  int errors;
  int pending;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_req;

  rms_level_meter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  rms_level_meter_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // output side: random stalls, plus a long hold-off on request
  initial begin
    int hold_seen;
    int hold_left;
    m_axis_tready = 1'b0;
    hold_seen = 0;
    hold_left = 0;
    forever @(negedge clk_i) begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("rms_level_meter_test failed");
    $finish;
  end

  function automatic logic [rlm_pkg::SAMPLE_W-1:0] pick_sample();
    int k;
    k = $urandom_range(9);
    case (k)
      5, 6:    return rlm_pkg::SAMPLE_W'($urandom_range(64) - 32);
      7: begin
        case ($urandom_range(4))
          0:       return 16'h7fff;
          1:       return 16'h8000;
          2:       return 16'h0000;
          3:       return 16'hffff;
          default: return 16'h0001;
        endcase
      end
      8, 9: begin
        // loud, near full scale of either sign
        if ($urandom_range(1)) begin
          return rlm_pkg::SAMPLE_W'(16'h6000 + $urandom_range(16'h1fff));
        end
        return rlm_pkg::SAMPLE_W'(16'h8000 + $urandom_range(16'h1fff));
      end
      default: return rlm_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic offer_frame(input logic [rlm_pkg::SAMPLE_W-1:0] left,
                             input logic [rlm_pkg::SAMPLE_W-1:0] right);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {right, left};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // stop offering, let every level drain, then give a block still in flight time to finish
  task automatic drain_levels();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [rlm_pkg::CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= rlm_pkg::CFG_W'(val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned frames, input int unsigned full_scale,
                           input int sidle, input int rstall, input int n);
    drain_levels();
    write_reg(rlm_pkg::REG_FRAMES, frames);
    write_reg(rlm_pkg::REG_FULL_SCALE, full_scale);
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    repeat (n) offer_frame(pick_sample(), pick_sample());
  endtask

  initial begin
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 0;
    rst_ni         = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // settings after reset: one full block of 256 frames
    repeat (256) offer_frame(pick_sample(), pick_sample());

    drain_levels();
    write_reg(rlm_pkg::REG_FRAMES, 1);
    write_reg(rlm_pkg::REG_FULL_SCALE, 16384);
    offer_frame(16'h7fff, 16'h7fff);
    offer_frame(16'h8000, 16'h8000);
    offer_frame(16'h0000, 16'h0000);
    offer_frame(16'hffff, 16'hffff);   // minus one halves to minus one
    offer_frame(16'h0001, 16'hffff);
    offer_frame(16'h8000, 16'h7fff);
    offer_frame(16'h5555, 16'haaaa);

    // full scale of one saturates the scaled level
    drain_levels();
    write_reg(rlm_pkg::REG_FULL_SCALE, 1);
    offer_frame(16'h7fff, 16'h8000);
    offer_frame(16'h0064, 16'hff9c);

    // full scale of zero acts as one
    drain_levels();
    write_reg(rlm_pkg::REG_FULL_SCALE, 0);
    offer_frame(16'h1234, 16'hedcc);

    // block length zero acts as one
    drain_levels();
    write_reg(rlm_pkg::REG_FRAMES, 0);
    offer_frame(16'h4000, 16'hc000);
    offer_frame(16'h0002, 16'hfffe);

    // shorten the block once five frames are in: the next frame closes it at six
    drain_levels();
    write_reg(rlm_pkg::REG_FRAMES, 8);
    repeat (5) offer_frame(pick_sample(), pick_sample());
    drain_levels();
    write_reg(rlm_pkg::REG_FRAMES, 3);
    offer_frame(pick_sample(), pick_sample());

    run_phase(1, 16384, 0, 0, 150);
    run_phase(3, 5571, 65, 0, 150);
    run_phase(7, 32767, 0, 65, 150);
    run_phase(16, 200, 25, 25, 160);
    run_phase(511, 16384, 0, 0, 256);   // above the maximum, acts as 256

    // output held off while frames keep coming, so the input stalls
    run_phase(2, 8000, 0, 0, 0);
    hold_req++;
    repeat (80) offer_frame(pick_sample(), pick_sample());

    repeat (3) begin
      run_phase($urandom_range(20, 1), $urandom_range(32767), 25, 25, 50);
    end

    drain_levels();
    if (errors == 0 && pending == 0) begin
      $display("rms_level_meter_test passed");
    end else begin
      $display("rms_level_meter_test failed");
    end
    $finish;
  end

endmodule

// ===== rms_level_meter.f =====
rtl/rlm_pkg.sv
rtl/rlm_ctrl.sv
rtl/rlm_datapath.sv
rtl/rms_level_meter.sv
test/rms_level_meter_checker.sv
test/rms_level_meter_test.sv
